// File: hdl/hsvrgb_pkg.sv
// constants, types and sector codes for the hsv to rgb pixel pipeline
// no dependencies; used by hsvrgb_skid and hsv_to_rgb_pixel_unit
package hsvrgb_pkg;

    localparam int HUE_W   = 16;
    localparam int LEVEL_W = 17;
    localparam int CHAN_W  = 8;
    localparam int REM_W   = 12;
    localparam int FRAC_W  = 16;
    localparam int SECT_W  = 3;

    localparam int IN_W      = HUE_W + 2 * LEVEL_W;
    localparam int IN_BYTE_W = ((IN_W + 7) / 8) * 8;
    localparam int PIXEL_W   = 3 * CHAN_W;

    localparam logic [LEVEL_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [HUE_W-1:0]   FULL_TURN   = 16'd23040;
    localparam logic [HUE_W-1:0]   SECTOR_SPAN = 16'd3840;

    // floor(x * 256 / 15) as (x * FRAC_RECIP) >> FRAC_SHIFT, exact for x < 3840
    localparam int                 FRAC_RECIP_W = 21;
    localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = 21'd1118482;
    localparam int                 FRAC_SHIFT   = 16;

    // 255.999 in q8.16
    localparam int                 SCALE_W       = 24;
    localparam logic [SCALE_W-1:0] CHANNEL_SCALE = 24'd16777150;
    localparam int                 CHAN_SHIFT    = 32;

    localparam logic [SECT_W-1:0] SECTOR_RED_YELLOW    = 3'd0;
    localparam logic [SECT_W-1:0] SECTOR_YELLOW_GREEN  = 3'd1;
    localparam logic [SECT_W-1:0] SECTOR_GREEN_CYAN    = 3'd2;
    localparam logic [SECT_W-1:0] SECTOR_CYAN_BLUE     = 3'd3;
    localparam logic [SECT_W-1:0] SECTOR_BLUE_MAGENTA  = 3'd4;
    localparam logic [SECT_W-1:0] SECTOR_MAGENTA_RED   = 3'd5;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

endpackage

// File: hdl/hsvrgb_skid.sv
// two-entry output skid buffer: registered ready towards the pipeline
// depends on hsvrgb_pkg for the default width
module hsvrgb_skid #(
    parameter int WIDTH = hsvrgb_pkg::PIXEL_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic [WIDTH-1:0] out_data_reg;
    logic [WIDTH-1:0] skid_data_reg;
    logic             accept;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (accept)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// File: hdl/hsv_to_rgb_pixel_unit.sv
// hsv to rgb pixel converter: top level, six-stage pipeline and output skid buffer
// depends on hsvrgb_pkg and hsvrgb_skid
//
// One pixel per clock while the output side is ready: a beat can be taken every cycle
// and its result moves through the stage registers in order and then on to the output
// register of the skid buffer. The stages are hue range check and sector split,
// fraction and p product, the two saturation products, the q and t products,
// channel selection and the final scale to 8 bits; no stage has more than one
// multiplier in series.
// When the output is held off the whole pipeline stops as one, and two results are
// kept in the skid buffer so no beat is lost; zero saturation falls out as grey.
module hsv_to_rgb_pixel_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // hue[15:0], saturation[32:16], brightness[49:33], zero fill up to bit 55
    input  logic [hsvrgb_pkg::IN_BYTE_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [hsvrgb_pkg::PIXEL_W-1:0]    m_axis_tdata
);

    localparam int LW = hsvrgb_pkg::LEVEL_W;
    localparam int NSTAGE = 6;

    logic              en;
    logic              skid_ready;
    logic [NSTAGE-1:0] vld_reg;

    // stage 1
    logic [hsvrgb_pkg::HUE_W-1:0]  hue_in;
    logic [LW-1:0]                 sat_in;
    logic [LW-1:0]                 val_in;
    logic [hsvrgb_pkg::HUE_W-1:0]  hue_wrap;
    logic [hsvrgb_pkg::SECT_W-1:0] sect_next;
    logic [hsvrgb_pkg::HUE_W-1:0]  base_next;
    logic [hsvrgb_pkg::HUE_W-1:0]  rem_full;
    logic [hsvrgb_pkg::SECT_W-1:0] sect1_reg;
    logic [hsvrgb_pkg::REM_W-1:0]  rem1_reg;
    logic [LW-1:0]                 sat1_reg;
    logic [LW-1:0]                 val1_reg;

    // stage 2
    logic [hsvrgb_pkg::REM_W+hsvrgb_pkg::FRAC_RECIP_W-1:0] frac_prod;
    logic [2*LW-1:0]               p_prod;
    logic [hsvrgb_pkg::FRAC_W-1:0] frac2_reg;
    logic [LW-1:0]                 p2_reg;
    logic [hsvrgb_pkg::SECT_W-1:0] sect2_reg;
    logic [LW-1:0]                 sat2_reg;
    logic [LW-1:0]                 val2_reg;

    // stage 3
    logic [LW+hsvrgb_pkg::FRAC_W-1:0] sf_prod;
    logic [2*LW-1:0]               st_prod;
    logic [LW-1:0]                 sf3_reg;
    logic [LW-1:0]                 st3_reg;
    logic [LW-1:0]                 p3_reg;
    logic [hsvrgb_pkg::SECT_W-1:0] sect3_reg;
    logic [LW-1:0]                 val3_reg;

    // stage 4
    logic [2*LW-1:0]               q_prod;
    logic [2*LW-1:0]               t_prod;
    logic [LW-1:0]                 q4_reg;
    logic [LW-1:0]                 t4_reg;
    logic [LW-1:0]                 p4_reg;
    logic [hsvrgb_pkg::SECT_W-1:0] sect4_reg;
    logic [LW-1:0]                 val4_reg;

    // stage 5
    logic [LW-1:0] r_next;
    logic [LW-1:0] g_next;
    logic [LW-1:0] b_next;
    logic [LW-1:0] r5_reg;
    logic [LW-1:0] g5_reg;
    logic [LW-1:0] b5_reg;

    // stage 6
    logic [LW+hsvrgb_pkg::SCALE_W-1:0] r_prod;
    logic [LW+hsvrgb_pkg::SCALE_W-1:0] g_prod;
    logic [LW+hsvrgb_pkg::SCALE_W-1:0] b_prod;
    hsvrgb_pkg::pixel_t                pix6_reg;

    assign en            = skid_ready || !vld_reg[NSTAGE-1];
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_axis_tvalid};
        end
    end

    // stage 1: clamp levels, zero an out-of-range hue, split into sector and remainder
    assign hue_in = s_axis_tdata[hsvrgb_pkg::HUE_W-1:0];
    assign sat_in = s_axis_tdata[hsvrgb_pkg::HUE_W +: LW];
    assign val_in = s_axis_tdata[hsvrgb_pkg::HUE_W+LW +: LW];

    always_comb
    begin
        hue_wrap = (hue_in >= hsvrgb_pkg::FULL_TURN) ? '0 : hue_in;
        if (hue_wrap >= 5 * hsvrgb_pkg::SECTOR_SPAN)
        begin
            sect_next = hsvrgb_pkg::SECTOR_MAGENTA_RED;
            base_next = 16'(5 * hsvrgb_pkg::SECTOR_SPAN);
        end
        else if (hue_wrap >= 4 * hsvrgb_pkg::SECTOR_SPAN)
        begin
            sect_next = hsvrgb_pkg::SECTOR_BLUE_MAGENTA;
            base_next = 16'(4 * hsvrgb_pkg::SECTOR_SPAN);
        end
        else if (hue_wrap >= 3 * hsvrgb_pkg::SECTOR_SPAN)
        begin
            sect_next = hsvrgb_pkg::SECTOR_CYAN_BLUE;
            base_next = 16'(3 * hsvrgb_pkg::SECTOR_SPAN);
        end
        else if (hue_wrap >= 2 * hsvrgb_pkg::SECTOR_SPAN)
        begin
            sect_next = hsvrgb_pkg::SECTOR_GREEN_CYAN;
            base_next = 16'(2 * hsvrgb_pkg::SECTOR_SPAN);
        end
        else if (hue_wrap >= hsvrgb_pkg::SECTOR_SPAN)
        begin
            sect_next = hsvrgb_pkg::SECTOR_YELLOW_GREEN;
            base_next = hsvrgb_pkg::SECTOR_SPAN;
        end
        else
        begin
            sect_next = hsvrgb_pkg::SECTOR_RED_YELLOW;
            base_next = '0;
        end
        rem_full = hue_wrap - base_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sect1_reg <= sect_next;
            rem1_reg  <= rem_full[hsvrgb_pkg::REM_W-1:0];
            sat1_reg  <= (sat_in > hsvrgb_pkg::ONE_Q16) ? hsvrgb_pkg::ONE_Q16 : sat_in;
            val1_reg  <= (val_in > hsvrgb_pkg::ONE_Q16) ? hsvrgb_pkg::ONE_Q16 : val_in;
        end
    end

    // stage 2: fraction within the sector and p
    assign frac_prod = rem1_reg * hsvrgb_pkg::FRAC_RECIP;
    assign p_prod    = val1_reg * (hsvrgb_pkg::ONE_Q16 - sat1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac2_reg <= frac_prod[hsvrgb_pkg::FRAC_SHIFT +: hsvrgb_pkg::FRAC_W];
            p2_reg    <= p_prod[16 +: LW];
            sect2_reg <= sect1_reg;
            sat2_reg  <= sat1_reg;
            val2_reg  <= val1_reg;
        end
    end

    // stage 3: saturation scaled by fraction and by its complement
    assign sf_prod = sat2_reg * frac2_reg;
    assign st_prod = sat2_reg * (hsvrgb_pkg::ONE_Q16 - {1'b0, frac2_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sf3_reg   <= sf_prod[16 +: LW];
            st3_reg   <= st_prod[16 +: LW];
            p3_reg    <= p2_reg;
            sect3_reg <= sect2_reg;
            val3_reg  <= val2_reg;
        end
    end

    // stage 4: q and t
    assign q_prod = val3_reg * (hsvrgb_pkg::ONE_Q16 - sf3_reg);
    assign t_prod = val3_reg * (hsvrgb_pkg::ONE_Q16 - st3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q4_reg    <= q_prod[16 +: LW];
            t4_reg    <= t_prod[16 +: LW];
            p4_reg    <= p3_reg;
            sect4_reg <= sect3_reg;
            val4_reg  <= val3_reg;
        end
    end

    // stage 5: pick levels per sector
    always_comb
    begin
        case (sect4_reg)
            hsvrgb_pkg::SECTOR_RED_YELLOW:
            begin
                r_next = val4_reg; g_next = t4_reg;   b_next = p4_reg;
            end
            hsvrgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                r_next = q4_reg;   g_next = val4_reg; b_next = p4_reg;
            end
            hsvrgb_pkg::SECTOR_GREEN_CYAN:
            begin
                r_next = p4_reg;   g_next = val4_reg; b_next = t4_reg;
            end
            hsvrgb_pkg::SECTOR_CYAN_BLUE:
            begin
                r_next = p4_reg;   g_next = q4_reg;   b_next = val4_reg;
            end
            hsvrgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                r_next = t4_reg;   g_next = p4_reg;   b_next = val4_reg;
            end
            default:
            begin
                r_next = val4_reg; g_next = p4_reg;   b_next = q4_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r5_reg <= r_next;
            g5_reg <= g_next;
            b5_reg <= b_next;
        end
    end

    // stage 6: scale each level to 8 bits
    assign r_prod = r5_reg * hsvrgb_pkg::CHANNEL_SCALE;
    assign g_prod = g5_reg * hsvrgb_pkg::CHANNEL_SCALE;
    assign b_prod = b5_reg * hsvrgb_pkg::CHANNEL_SCALE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix6_reg.red   <= r_prod[hsvrgb_pkg::CHAN_SHIFT +: hsvrgb_pkg::CHAN_W];
            pix6_reg.green <= g_prod[hsvrgb_pkg::CHAN_SHIFT +: hsvrgb_pkg::CHAN_W];
            pix6_reg.blue  <= b_prod[hsvrgb_pkg::CHAN_SHIFT +: hsvrgb_pkg::CHAN_W];
        end
    end

    hsvrgb_skid #(
        .WIDTH (hsvrgb_pkg::PIXEL_W)
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[NSTAGE-1]),
        .in_ready  (skid_ready),
        .in_data   (pix6_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // a frozen pipeline keeps its valid bits
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // sector split stays in range
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (sect1_reg <= hsvrgb_pkg::SECTOR_MAGENTA_RED)
                       && (rem1_reg < hsvrgb_pkg::SECTOR_SPAN))
        else $error("sector or remainder out of range");

    // q, t and p never exceed the value level
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] |-> (q4_reg <= val4_reg) && (t4_reg <= val4_reg)
                       && (p4_reg <= val4_reg))
        else $error("derived level above value");

    // a valid result waiting at stage six is never dropped
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NSTAGE-1] && !skid_ready |=> vld_reg[NSTAGE-1])
        else $error("result lost at pipeline exit");

endmodule

// File: test/tb_top.sv
// testbench for hsv_to_rgb_pixel_unit: directed and random hsv pixels, each rgb beat
// checked against an in-bench fixed-point model; depends on hsvrgb_pkg and the dut
`timescale 1ns / 100ps

module tb_top;

    localparam int HUE_W     = hsvrgb_pkg::HUE_W;
    localparam int LEVEL_W   = hsvrgb_pkg::LEVEL_W;
    localparam int CHAN_W    = hsvrgb_pkg::CHAN_W;
    localparam int SECT_W    = hsvrgb_pkg::SECT_W;
    localparam int IN_BYTE_W = hsvrgb_pkg::IN_BYTE_W;
    localparam int PIXEL_W   = hsvrgb_pkg::PIXEL_W;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // hue[15:0], saturation[32:16], brightness[49:33], zero fill up to bit 55
    logic [IN_BYTE_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // red[7:0], green[15:8], blue[23:16]
    logic [PIXEL_W-1:0]   m_axis_tdata;

    hsvrgb_pkg::pixel_t pending_rgb[$];
    bit     idling_on = 1'b1;
    int     beats_sent = 0;
    int     rgb_checked = 0;
    int     mismatch_count = 0;

    hsv_to_rgb_pixel_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // level in q1.16 to 8-bit channel, floor of level times 255.999
    function automatic logic [CHAN_W-1:0] level_to_chan(logic [63:0] level);
        return CHAN_W'((level * hsvrgb_pkg::CHANNEL_SCALE) >> hsvrgb_pkg::CHAN_SHIFT);
    endfunction

    function automatic hsvrgb_pkg::pixel_t rgb_of_hsv(logic [HUE_W-1:0] hue,
                                                      logic [LEVEL_W-1:0] sat,
                                                      logic [LEVEL_W-1:0] bri);
        logic [63:0]        h;
        logic [63:0]        s;
        logic [63:0]        v;
        logic [63:0]        frac;
        logic [63:0]        p;
        logic [63:0]        q;
        logic [63:0]        t;
        logic [63:0]        r;
        logic [63:0]        g;
        logic [63:0]        b;
        logic [SECT_W-1:0]  sector;
        hsvrgb_pkg::pixel_t px;
        s = (sat > hsvrgb_pkg::ONE_Q16) ? 64'(hsvrgb_pkg::ONE_Q16) : 64'(sat);
        v = (bri > hsvrgb_pkg::ONE_Q16) ? 64'(hsvrgb_pkg::ONE_Q16) : 64'(bri);
        if (s == 0)
        begin
            r = v;
            g = v;
            b = v;
        end
        else
        begin
            h      = (hue >= hsvrgb_pkg::FULL_TURN) ? 64'd0 : 64'(hue);
            sector = SECT_W'(h / hsvrgb_pkg::SECTOR_SPAN);
            frac   = ((h % hsvrgb_pkg::SECTOR_SPAN) * 64'd256) / 64'd15;
            p      = (v * (hsvrgb_pkg::ONE_Q16 - s)) >> 16;
            q      = (v * (hsvrgb_pkg::ONE_Q16 - ((s * frac) >> 16))) >> 16;
            t      = (v * (hsvrgb_pkg::ONE_Q16
                           - ((s * (hsvrgb_pkg::ONE_Q16 - frac)) >> 16))) >> 16;
            case (sector)
                hsvrgb_pkg::SECTOR_RED_YELLOW:
                begin
                    r = v; g = t; b = p;
                end
                hsvrgb_pkg::SECTOR_YELLOW_GREEN:
                begin
                    r = q; g = v; b = p;
                end
                hsvrgb_pkg::SECTOR_GREEN_CYAN:
                begin
                    r = p; g = v; b = t;
                end
                hsvrgb_pkg::SECTOR_CYAN_BLUE:
                begin
                    r = p; g = q; b = v;
                end
                hsvrgb_pkg::SECTOR_BLUE_MAGENTA:
                begin
                    r = t; g = p; b = v;
                end
                default:
                begin
                    r = v; g = p; b = q;
                end
            endcase
        end
        px.red   = level_to_chan(r);
        px.green = level_to_chan(g);
        px.blue  = level_to_chan(b);
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("%0t: mismatch on %s after %0d pixels: got %0d, want %0d",
                     $time, what, rgb_checked, got, want);
    endtask

    // one hsv beat; may idle first, leaves tvalid high after the accepting edge
    task automatic send_pixel(logic [HUE_W-1:0] hue, logic [LEVEL_W-1:0] sat,
                              logic [LEVEL_W-1:0] bri);
        while (idling_on && $urandom_range(99) < 10)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_BYTE_W'({$urandom, $urandom});
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BYTE_W'({bri, sat, hue});
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_rgb.push_back(rgb_of_hsv(hue, sat, bri));
        beats_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rgb.size() != 0);
    endtask

    function automatic logic [HUE_W-1:0] rand_hue();
        int pick;
        int edge_sel;
        pick = $urandom_range(99);
        if (pick < 70)
            return HUE_W'($urandom_range(23039));
        if (pick < 85)
            return HUE_W'($urandom);
        // close to a sector boundary or the full turn
        edge_sel = $urandom_range(1, 6);
        return HUE_W'(edge_sel * 3840 + $urandom_range(4) - 2);
    endfunction

    function automatic logic [LEVEL_W-1:0] rand_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 16)
            return hsvrgb_pkg::ONE_Q16;
        if (pick < 26)
            return LEVEL_W'($urandom_range(131071, 65537));
        if (pick < 32)
            return LEVEL_W'($urandom_range(15));
        return LEVEL_W'($urandom_range(65535, 1));
    endfunction

    task automatic test_level_extremes();
        send_pixel(16'd0, 17'd0, 17'd0);
        send_pixel(16'd0, 17'd0, hsvrgb_pkg::ONE_Q16);
        send_pixel(16'd0, hsvrgb_pkg::ONE_Q16, hsvrgb_pkg::ONE_Q16);
        send_pixel(16'hffff, 17'h1ffff, 17'h1ffff);
        send_pixel(16'h5555, 17'd65537, 17'd65537);
        send_pixel(16'haaaa, 17'h0aaaa, 17'h15555);
        send_pixel(16'd11520, 17'd1, hsvrgb_pkg::ONE_Q16);
        send_pixel(16'd7000, 17'd65535, 17'd1);
    endtask

    task automatic test_sector_edges();
        int edges[10] = '{3839, 3840, 7679, 7680, 11520, 15359, 15360, 19200, 23039, 23040};
        foreach (edges[i])
            send_pixel(HUE_W'(edges[i]), hsvrgb_pkg::ONE_Q16, hsvrgb_pkg::ONE_Q16);
    endtask

    // zero saturation must come out grey whatever the hue
    task automatic test_grey();
        send_pixel(16'd40000, 17'd0, 17'd32768);
        send_pixel(16'd5000, 17'd0, 17'h1ffff);
        send_pixel(16'd23039, 17'd0, 17'd255);
    endtask

    task automatic test_random_pixels(int count);
        repeat (count)
            send_pixel(rand_hue(), rand_level(), rand_level());
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        test_random_pixels(400);
        idling_on = 1'b1;
    endtask

    // sender holds off until the pipe and skid buffer are empty, then restarts
    task automatic test_drain_restart();
        test_random_pixels(200);
        wait_drained();
        test_random_pixels(400);
    endtask

    always @(posedge clk)
        m_axis_tready <= idling_on ? ($urandom_range(99) >= 10) : 1'b1;

    always @(posedge clk)
    begin
        hsvrgb_pkg::pixel_t got;
        hsvrgb_pkg::pixel_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_rgb.size() == 0)
                report_mismatch("unexpected rgb beat", got, 0);
            else
            begin
                want = pending_rgb.pop_front();
                if (got.red !== want.red)
                    report_mismatch("red", got.red, want.red);
                if (got.green !== want.green)
                    report_mismatch("green", got.green, want.green);
                if (got.blue !== want.blue)
                    report_mismatch("blue", got.blue, want.blue);
                rgb_checked++;
            end
        end
    end

    initial
    begin
        #1ms;
        $display("timeout with %0d pixels outstanding", pending_rgb.size());
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_level_extremes();
        test_sector_edges();
        test_grey();
        test_random_pixels(900);
        test_back_to_back();
        test_drain_restart();

        wait_drained();
        repeat (20) @(posedge clk);

        $display("%0d hsv beats sent, %0d rgb beats checked: sector edges, grey, levels",
                 beats_sent, rgb_checked);
        $display("above one, wrapped hues, random stalls and a full drain and restart");
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
